[design/boundary_tag_heap_allocator_assert.svh]
// Assertion macros shared by the checker.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BTHA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btha: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BTHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btha: next-cycle check failed");

`endif

[design/btha_pkg.sv]
// ----------------------------------------------------------------------------
// btha_pkg
// Types and codes for the boundary-tag heap allocator.
// ----------------------------------------------------------------------------
package btha_pkg;

    typedef enum logic [1:0] {
        KIND_INIT  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_FREE  = 2'd2,
        KIND_NOP   = 2'd3
    } t_kind;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_ZERO   = 2'd1;
    localparam logic [1:0] STATUS_NOMEM  = 2'd2;
    localparam logic [1:0] STATUS_NOINIT = 2'd3;

    localparam logic [16:0] CHUNK_RESET = 17'd2048;

    typedef enum logic [1:0] {
        RET_INIT,
        RET_ALLOC,
        RET_FREE
    } t_ret;

    typedef enum logic [5:0] {
        ST_IDLE, ST_DISP,
        ST_I0, ST_I1, ST_I2, ST_I3,
        ST_G0, ST_G1, ST_G2,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
        ST_MR, ST_MC,
        ST_S1, ST_S1W, ST_S2, ST_S2W,
        ST_T0, ST_T1, ST_T2, ST_T3, ST_T4, ST_T6,
        ST_F1, ST_F2, ST_F3,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [15:0] payload_address;
        logic [1:0]  status;
    } t_result;

endpackage

[design/btha_tag_ram.sv]
// ----------------------------------------------------------------------------
// btha_tag_ram
// Single-port tag memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module btha_tag_ram #(
    parameter int DEPTH = 16384,
    parameter int IW    = 14,
    parameter int TW    = 17
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_we,
    input  logic [IW-1:0] i_idx,
    input  logic [TW-1:0] i_wdata,
    output logic [TW-1:0] o_rdata
);

    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_idx] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_idx];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/btha_ctrl.sv]
// ----------------------------------------------------------------------------
// btha_ctrl
// Request sequencer: init, allocate (next-fit walk, grow, split) and free
// (check, clear, coalesce), all as read/modify/write steps on the tag memory.
// ----------------------------------------------------------------------------
module btha_ctrl
    import btha_pkg::*;
#(
    parameter int HEAP_BYTES = 65536,
    parameter int DEPTH      = 16384,
    parameter int IW         = 14,
    parameter int TW         = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_kind,
    input  logic [15:0]   i_request_bytes,
    input  logic [15:0]   i_block_address,
    input  logic [16:0]   i_chunk_bytes,
    input  logic          i_out_free,
    output logic          o_busy,
    output logic          o_done,
    output t_result       o_result,
    output logic          o_mem_en,
    output logic          o_mem_we,
    output logic [IW-1:0] o_mem_idx,
    output logic [TW-1:0] o_mem_wdata,
    input  logic [TW-1:0] i_mem_rdata
);

    localparam int W     = ($clog2(HEAP_BYTES) + 2 > 19) ? $clog2(HEAP_BYTES) + 2 : 19;
    localparam int LIMIT = HEAP_BYTES / 8 + 4;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam logic [W-1:0] HEAP_W = W'(HEAP_BYTES);

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;
    t_kind  r_kind, n_kind;
    logic [15:0]   r_req, n_req;
    logic [15:0]   r_addr, n_addr;
    logic [W-1:0]  r_asize, n_asize;
    logic [W-1:0]  r_bp, n_bp;
    logic [W-1:0]  r_size, n_size;
    logic [W-1:0]  r_psz, n_psz;
    logic [W-1:0]  r_nb, n_nb;
    logic [W-1:0]  r_nsz, n_nsz;
    logic [W-1:0]  r_h, n_h;
    logic [W-1:0]  r_start, n_start;
    logic [W-1:0]  r_ext, n_ext;
    logic [W-1:0]  r_brk, n_brk;
    logic [W-1:0]  r_rover, n_rover;
    logic [CW-1:0] r_n, n_n;
    logic          r_pa, n_pa;
    logic          r_init, n_init;
    logic          r_rd_oob, n_rd_oob;
    logic [15:0]   r_pay, n_pay;
    logic [1:0]    r_status, n_status;

    logic          acc_req, acc_we, in_range;
    logic [W-1:0]  acc_addr, acc_wdata;

    logic [W-1:0]  rd, rd_sz, addr_w, pb, chunk_eff, asize_calc;
    logic [17:0]   chunk_rnd;
    logic          free_pre, grow_fail, fit, f1_ok, split, short_blk, walk_ok, wrap_ok;
    t_state        ret_state;

    // out-of-range tag reads return zero
    assign rd     = r_rd_oob ? '0 : W'(i_mem_rdata);
    assign rd_sz  = {rd[W-1:3], 3'b000};
    assign addr_w = W'(r_addr);
    assign pb     = r_bp - r_psz;

    assign chunk_rnd  = ({1'b0, i_chunk_bytes} + 18'd7) & ~18'd7;
    assign chunk_eff  = (chunk_rnd < 18'd16) ? W'(16) : W'(chunk_rnd);
    assign asize_calc = (r_req <= 16'd8) ? W'(16) : ((W'(r_req) + W'(15)) & ~W'(7));

    assign free_pre  = (r_addr != 16'd0) && (r_addr[2:0] == 3'b000) &&
                       (addr_w >= W'(16)) && (addr_w < r_brk);
    assign grow_fail = (r_ext > HEAP_W) || (r_brk > HEAP_W - r_ext);
    assign fit       = !rd[0] && (r_asize <= rd_sz);
    assign f1_ok     = rd[0] && (rd_sz >= W'(16)) && (rd_sz <= r_brk - addr_w);
    assign short_blk = rd_sz < r_asize;
    assign split     = (rd_sz - r_asize) >= W'(16);
    assign walk_ok   = r_n < CW'(LIMIT);
    assign wrap_ok   = walk_ok && (r_rover < r_start);
    assign ret_state = (r_ret == RET_ALLOC) ? ST_T0 : ST_FIN;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_DISP;
            ST_DISP: begin
                unique case (r_kind)
                    KIND_INIT:  n_state = ST_I0;
                    KIND_ALLOC: n_state = (!r_init || r_req == 16'd0) ? ST_FIN : ST_S1;
                    KIND_FREE:  n_state = (r_init && free_pre) ? ST_F1 : ST_FIN;
                    default:    n_state = ST_FIN;
                endcase
            end
            ST_I0:  n_state = ST_I1;
            ST_I1:  n_state = ST_I2;
            ST_I2:  n_state = ST_I3;
            ST_I3:  n_state = ST_G0;
            ST_G0:  n_state = grow_fail ? ST_FIN : ST_G1;
            ST_G1:  n_state = ST_G2;
            ST_G2:  n_state = ST_M0;
            ST_M0:  n_state = ST_M1;
            ST_M1:  n_state = ST_M2;
            ST_M2:  n_state = ST_M3;
            ST_M3: begin
                priority if (r_pa && rd[0]) n_state = ret_state;
                else if (r_pa)              n_state = ST_M4;
                else if (rd[0])             n_state = ST_M5;
                else                        n_state = ST_M8;
            end
            ST_M4:  n_state = ST_MR;
            ST_M5:  n_state = ST_M6;
            ST_M6:  n_state = ST_M7;
            ST_M7:  n_state = ST_MR;
            ST_M8:  n_state = ST_M9;
            ST_M9:  n_state = ST_MR;
            ST_MR:  n_state = ST_MC;
            ST_MC:  n_state = ret_state;
            ST_S1:  n_state = walk_ok ? ST_S1W : ST_S2;
            ST_S1W: begin
                priority if (rd_sz == '0) n_state = ST_S2;
                else if (fit)             n_state = ST_T0;
                else                      n_state = ST_S1;
            end
            ST_S2:  n_state = wrap_ok ? ST_S2W : ST_G0;
            ST_S2W: n_state = fit ? ST_T0 : ST_S2;
            ST_T0:  n_state = ST_T1;
            ST_T1: begin
                priority if (short_blk) n_state = ST_FIN;
                else if (split)         n_state = ST_T2;
                else                    n_state = ST_T6;
            end
            ST_T2:  n_state = ST_T3;
            ST_T3:  n_state = ST_T4;
            ST_T4:  n_state = ST_FIN;
            ST_T6:  n_state = ST_FIN;
            ST_F1:  n_state = f1_ok ? ST_F2 : ST_FIN;
            ST_F2:  n_state = (rd == r_h) ? ST_F3 : ST_FIN;
            ST_F3:  n_state = ST_M0;
            ST_FIN: if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory accesses
    always_comb begin
        n_ret    = r_ret;
        n_kind   = r_kind;
        n_req    = r_req;
        n_addr   = r_addr;
        n_asize  = r_asize;
        n_bp     = r_bp;
        n_size   = r_size;
        n_psz    = r_psz;
        n_nb     = r_nb;
        n_nsz    = r_nsz;
        n_h      = r_h;
        n_start  = r_start;
        n_ext    = r_ext;
        n_brk    = r_brk;
        n_rover  = r_rover;
        n_n      = r_n;
        n_pa     = r_pa;
        n_init   = r_init;
        n_pay    = r_pay;
        n_status = r_status;
        acc_req   = 1'b0;
        acc_we    = 1'b0;
        acc_addr  = '0;
        acc_wdata = '0;
        o_done    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_kind   = t_kind'(i_kind);
                    n_req    = i_request_bytes;
                    n_addr   = i_block_address;
                    n_pay    = '0;
                    n_status = STATUS_OK;
                end
            end
            ST_DISP: begin
                unique case (r_kind)
                    KIND_ALLOC: begin
                        priority if (!r_init)       n_status = STATUS_NOINIT;
                        else if (r_req == 16'd0)    n_status = STATUS_ZERO;
                        else begin
                            n_asize = asize_calc;
                            n_start = r_rover;
                            n_n     = '0;
                        end
                    end
                    KIND_FREE: begin
                        if (!r_init) begin
                            n_status = STATUS_NOINIT;
                        end else if (free_pre) begin
                            acc_req  = 1'b1;
                            acc_addr = addr_w - W'(4);
                        end
                    end
                    default: ;
                endcase
            end
            ST_I0: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = '0; acc_wdata = '0;
                n_brk   = W'(16);
                n_rover = W'(8);
                n_init  = 1'b1;
            end
            ST_I1: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = W'(4); acc_wdata = W'(9);
            end
            ST_I2: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = W'(8); acc_wdata = W'(9);
            end
            ST_I3: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = W'(12); acc_wdata = W'(1);
                n_ext = chunk_eff;
                n_ret = RET_INIT;
            end
            ST_G0: begin
                if (grow_fail) begin
                    n_status = STATUS_NOMEM;
                end else begin
                    n_brk  = r_brk + r_ext;
                    n_bp   = r_brk;
                    n_size = r_ext;
                    acc_req = 1'b1; acc_we = 1'b1;
                    acc_addr = r_brk - W'(4); acc_wdata = r_ext;
                end
            end
            ST_G1: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_size - W'(8); acc_wdata = r_size;
            end
            ST_G2: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_size - W'(4); acc_wdata = W'(1);
            end
            ST_M0: begin
                acc_req = 1'b1; acc_addr = r_bp - W'(4);
            end
            ST_M1: begin
                n_size  = rd_sz;
                acc_req = 1'b1; acc_addr = r_bp - W'(8);
            end
            ST_M2: begin
                n_pa    = rd[0];
                n_psz   = rd_sz;
                n_nb    = r_bp + r_size;
                acc_req = 1'b1; acc_addr = r_bp + r_size - W'(4);
            end
            ST_M3: begin
                n_nsz = rd_sz;
                if (r_pa && !rd[0]) begin
                    n_size  = r_size + rd_sz;
                    acc_req = 1'b1; acc_we = 1'b1;
                    acc_addr = r_bp - W'(4); acc_wdata = r_size + rd_sz;
                end else if (!r_pa) begin
                    acc_req = 1'b1; acc_addr = pb - W'(4);
                end
            end
            ST_M4: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_size - W'(8); acc_wdata = r_size;
            end
            ST_M5: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_size - W'(8); acc_wdata = r_size + rd_sz;
            end
            ST_M6: begin
                // previous block header is read again after the footer write
                acc_req = 1'b1; acc_addr = pb - W'(4);
            end
            ST_M7: begin
                n_size  = r_size + rd_sz;
                n_bp    = pb;
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = pb - W'(4); acc_wdata = r_size + rd_sz;
            end
            ST_M8: begin
                n_size  = r_size + rd_sz + r_nsz;
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = pb - W'(4); acc_wdata = r_size + rd_sz + r_nsz;
            end
            ST_M9: begin
                n_bp    = pb;
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_nb + r_nsz - W'(8); acc_wdata = r_size;
            end
            ST_MR: begin
                acc_req = 1'b1; acc_addr = r_bp - W'(4);
            end
            ST_MC: begin
                if (r_rover > r_bp && r_rover < r_bp + rd_sz) n_rover = r_bp;
            end
            ST_S1: begin
                if (walk_ok) begin
                    acc_req = 1'b1; acc_addr = r_rover - W'(4);
                end else begin
                    n_rover = W'(8);
                    n_n     = '0;
                end
            end
            ST_S1W: begin
                priority if (rd_sz == '0) begin
                    n_rover = W'(8);
                    n_n     = '0;
                end else if (fit) begin
                    n_bp = r_rover;
                end else begin
                    n_rover = r_rover + rd_sz;
                    n_n     = r_n + CW'(1);
                end
            end
            ST_S2: begin
                if (wrap_ok) begin
                    acc_req = 1'b1; acc_addr = r_rover - W'(4);
                end else begin
                    n_ext = (r_asize > chunk_eff) ? r_asize : chunk_eff;
                    n_ret = RET_ALLOC;
                end
            end
            ST_S2W: begin
                if (fit) begin
                    n_bp = r_rover;
                end else begin
                    n_rover = r_rover + rd_sz;
                    n_n     = r_n + CW'(1);
                end
            end
            ST_T0: begin
                acc_req = 1'b1; acc_addr = r_bp - W'(4);
            end
            ST_T1: begin
                n_size = rd_sz;
                n_pay  = r_bp[15:0];
                if (!short_blk) begin
                    acc_req = 1'b1; acc_we = 1'b1;
                    acc_addr  = r_bp - W'(4);
                    acc_wdata = split ? (r_asize | W'(1)) : (rd_sz | W'(1));
                end
            end
            ST_T2: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_asize - W'(8); acc_wdata = r_asize | W'(1);
            end
            ST_T3: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_asize - W'(4); acc_wdata = r_size - r_asize;
            end
            ST_T4: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_size - W'(8); acc_wdata = r_size - r_asize;
            end
            ST_T6: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = r_bp + r_size - W'(8); acc_wdata = r_size | W'(1);
            end
            ST_F1: begin
                n_h    = rd;
                n_size = rd_sz;
                if (f1_ok) begin
                    acc_req = 1'b1; acc_addr = addr_w + rd_sz - W'(8);
                end
            end
            ST_F2: begin
                if (rd == r_h) begin
                    acc_req = 1'b1; acc_we = 1'b1;
                    acc_addr = addr_w - W'(4); acc_wdata = r_size;
                end
            end
            ST_F3: begin
                acc_req = 1'b1; acc_we = 1'b1;
                acc_addr = addr_w + r_size - W'(8); acc_wdata = r_size;
                n_bp  = addr_w;
                n_ret = RET_FREE;
            end
            ST_FIN: o_done = i_out_free;
            default: ;
        endcase
    end

    assign in_range    = acc_addr[W-1:2] < (W-2)'(DEPTH);
    assign o_mem_en    = acc_req && in_range;
    assign o_mem_we    = acc_we;
    assign o_mem_idx   = acc_addr[IW+1:2];
    assign o_mem_wdata = acc_wdata[TW-1:0];
    assign n_rd_oob    = acc_req && !acc_we && !in_range;

    assign o_busy   = (r_state != ST_IDLE);
    assign o_result = '{payload_address: r_pay, status: r_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_brk    <= '0;
            r_rover  <= '0;
            r_init   <= 1'b0;
            r_rd_oob <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_brk    <= n_brk;
            r_rover  <= n_rover;
            r_init   <= n_init;
            r_rd_oob <= n_rd_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_kind   <= n_kind;
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_asize  <= n_asize;
        r_bp     <= n_bp;
        r_size   <= n_size;
        r_psz    <= n_psz;
        r_nb     <= n_nb;
        r_nsz    <= n_nsz;
        r_h      <= n_h;
        r_start  <= n_start;
        r_ext    <= n_ext;
        r_n      <= n_n;
        r_pa     <= n_pa;
        r_pay    <= n_pay;
        r_status <= n_status;
    end

endmodule

[design/boundary_tag_heap_allocator.sv]
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// Boundary-tag heap allocator, implicit free list with next-fit search.
//
//   channel | dir | handshake             | payload
//   req     | in  | i_req_valid/o_req_stall | i_kind, i_request_bytes, i_block_address
//   rsp     | out | o_rsp_valid/i_rsp_stall | o_payload_address, o_status
//   cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_chunk_bytes
//
// One request at a time; every tag access goes through the single-port tag
// memory. Allocate takes longer for each block visited by the next-fit walk,
// for the wrap, and when the heap grows; init is shorter when the first
// chunk does not fit, and free is shorter when the request is rejected.
// A stalled response holds the sequencer in its last state.
// Synchronous reset clears control state; tag memory is not cleared.
// A new request is taken while the previous result waits in the output reg.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator
    import btha_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_block_address,
    output logic        o_rsp_valid,
    input  logic        i_rsp_stall,
    output logic [15:0] o_payload_address,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_chunk_bytes
);

    localparam int DEPTH = HEAP_BYTES / 4;
    localparam int IW    = $clog2(DEPTH);
    localparam int TW    = $clog2(HEAP_BYTES) + 1;

    logic          busy, done, out_free, start;
    t_result       result;
    logic          mem_en, mem_we;
    logic [IW-1:0] mem_idx;
    logic [TW-1:0] mem_wdata, mem_rdata;

    logic [16:0]   r_chunk_bytes;
    logic          r_rsp_valid;
    logic [15:0]   r_pay;
    logic [1:0]    r_status;

    assign o_cfg_ready = 1'b1;
    assign o_req_stall = busy;
    assign start       = i_req_valid && !busy;
    assign out_free    = !r_rsp_valid || !i_rsp_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_bytes <= CHUNK_RESET;
            r_rsp_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_chunk_bytes <= i_cfg_chunk_bytes;
            if (done) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_pay    <= result.payload_address;
            r_status <= result.status;
        end
    end

    assign o_rsp_valid       = r_rsp_valid;
    assign o_payload_address = r_pay;
    assign o_status          = r_status;

    btha_ctrl #(
        .HEAP_BYTES (HEAP_BYTES),
        .DEPTH      (DEPTH),
        .IW         (IW),
        .TW         (TW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_kind          (i_kind),
        .i_request_bytes (i_request_bytes),
        .i_block_address (i_block_address),
        .i_chunk_bytes   (r_chunk_bytes),
        .i_out_free      (out_free),
        .o_busy          (busy),
        .o_done          (done),
        .o_result        (result),
        .o_mem_en        (mem_en),
        .o_mem_we        (mem_we),
        .o_mem_idx       (mem_idx),
        .o_mem_wdata     (mem_wdata),
        .i_mem_rdata     (mem_rdata)
    );

    btha_tag_ram #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .TW    (TW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_idx   (mem_idx),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

[design/btha_checker.sv]
// ----------------------------------------------------------------------------
// btha_checker
// Port-level checks for the heap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "boundary_tag_heap_allocator_assert.svh"

module btha_checker
    import btha_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        o_req_stall,
    input logic [1:0]  i_kind,
    input logic [15:0] i_request_bytes,
    input logic [15:0] i_block_address,
    input logic        o_rsp_valid,
    input logic        i_rsp_stall,
    input logic [15:0] o_payload_address,
    input logic [1:0]  o_status,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [16:0] i_cfg_chunk_bytes
);

    `BTHA_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && i_rsp_stall, o_rsp_valid && $stable(o_payload_address) && $stable(o_status))

    // a taken request keeps the sequencer busy for at least the next cycle
    `BTHA_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall)

    // failed requests never hand out an address
    `BTHA_ASSERT_NOW(a_fail_null, i_clk, i_rst_n, o_rsp_valid && o_status != STATUS_OK, o_payload_address == 16'd0)

    `BTHA_ASSERT_NOW(a_pay_aligned, i_clk, i_rst_n, o_rsp_valid, o_payload_address[2:0] == 3'b000)

endmodule

bind boundary_tag_heap_allocator btha_checker u_btha_checker (.*);

[dv/tb_boundary_tag_heap_allocator.sv]
// ----------------------------------------------------------------------------
// tb_boundary_tag_heap_allocator
// Self-checking bench for the boundary-tag heap allocator. A behavioral heap
// model predicts every response as the request is queued. A burst-driven
// sender and a stalling receiver run the request and response channels, and
// the chunk register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_boundary_tag_heap_allocator;
    import btha_pkg::*;

    localparam int unsigned HEAP  = 65536;
    localparam int unsigned TAGW  = HEAP / 4;
    localparam int unsigned WALKN = HEAP / 8 + 4;
    localparam int unsigned PRO   = 8;
    localparam int          QUIET_LIMIT = 300000;

    typedef struct {
        t_kind       kind;
        logic [15:0] nbytes;
        logic [15:0] addr;
    } t_request;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_req_valid;
    logic        o_req_stall;
    logic [1:0]  i_kind;
    logic [15:0] i_request_bytes;
    logic [15:0] i_block_address;
    logic        o_rsp_valid;
    logic        i_rsp_stall;
    logic [15:0] o_payload_address;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_chunk_bytes;

    boundary_tag_heap_allocator #(.HEAP_BYTES(HEAP)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_req_valid),
        .o_req_stall       (o_req_stall),
        .i_kind            (i_kind),
        .i_request_bytes   (i_request_bytes),
        .i_block_address   (i_block_address),
        .o_rsp_valid       (o_rsp_valid),
        .i_rsp_stall       (i_rsp_stall),
        .o_payload_address (o_payload_address),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_chunk_bytes (i_cfg_chunk_bytes)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ---------------- heap model ----------------
    int unsigned heap_tags [TAGW];
    int unsigned brk;
    int unsigned rov;
    bit          heap_up;
    logic [16:0] chunk_reg;

    t_request    pending_requests [$];
    t_result     predicted_results [$];
    int unsigned live_blocks [$];
    int unsigned ever_blocks [$];

    int  fail_count;
    int  holdoff_asks;
    bit  sender_hold;

    function automatic int unsigned tag_rd(int unsigned a);
        int unsigned i;
        i = a >> 2;
        return (i < TAGW) ? heap_tags[i] : 0;
    endfunction

    function automatic void tag_wr(int unsigned a, int unsigned v);
        int unsigned i;
        i = a >> 2;
        if (i < TAGW) heap_tags[i] = v;
    endfunction

    function automatic int unsigned blk_size(int unsigned bp);
        return tag_rd(bp - 4) & ~32'd7;
    endfunction

    function automatic int unsigned blk_used(int unsigned bp);
        return tag_rd(bp - 4) & 32'd1;
    endfunction

    function automatic int unsigned coalesce(int unsigned bp);
        int unsigned sz, pa, nb, na, pb, nsz;
        sz = blk_size(bp);
        pa = tag_rd(bp - 8) & 1;
        nb = bp + sz;
        na = blk_used(nb);
        if (pa != 0 && na != 0) return bp;
        if (pa != 0) begin
            sz += blk_size(nb);
            tag_wr(bp - 4, sz);
            tag_wr(bp + sz - 8, sz);
        end else if (na != 0) begin
            pb = bp - (tag_rd(bp - 8) & ~32'd7);
            tag_wr(bp + sz - 8, sz + blk_size(pb));
            sz += blk_size(pb);
            tag_wr(pb - 4, sz);
            bp = pb;
        end else begin
            pb = bp - (tag_rd(bp - 8) & ~32'd7);
            nsz = blk_size(nb);
            sz += blk_size(pb) + nsz;
            tag_wr(pb - 4, sz);
            tag_wr(nb + nsz - 8, sz);
            bp = pb;
        end
        if (rov > bp && rov < bp + blk_size(bp)) rov = bp;
        return bp;
    endfunction

    function automatic int unsigned grow_heap(int unsigned sz);
        int unsigned bp;
        bp = brk;
        if (sz > HEAP || bp > HEAP - sz) return 0;
        brk = bp + sz;
        tag_wr(bp - 4, sz);
        tag_wr(bp + sz - 8, sz);
        tag_wr(bp + sz - 4, 1);
        return coalesce(bp);
    endfunction

    function automatic int unsigned next_fit_scan(int unsigned asize);
        int unsigned start, n;
        start = rov;
        for (n = 0; n < WALKN && blk_size(rov) > 0; n++) begin
            if (blk_used(rov) == 0 && asize <= blk_size(rov)) return rov;
            rov += blk_size(rov);
        end
        rov = PRO;
        for (n = 0; n < WALKN && rov < start; n++) begin
            if (blk_used(rov) == 0 && asize <= blk_size(rov)) return rov;
            rov += blk_size(rov);
        end
        return 0;
    endfunction

    function automatic void place_block(int unsigned bp, int unsigned asize);
        int unsigned csize;
        csize = blk_size(bp);
        if (csize < asize) return;
        if (csize - asize >= 16) begin
            tag_wr(bp - 4, asize | 1);
            tag_wr(bp + asize - 8, asize | 1);
            bp += asize;
            tag_wr(bp - 4, csize - asize);
            tag_wr(bp + csize - asize - 8, csize - asize);
        end else begin
            tag_wr(bp - 4, csize | 1);
            tag_wr(bp + csize - 8, csize | 1);
        end
    endfunction

    function automatic int unsigned chunk_rounded();
        int unsigned c;
        c = (int'(chunk_reg) + 7) & ~32'd7;
        return (c < 16) ? 16 : c;
    endfunction

    function automatic t_result heap_outcome(t_request rq);
        t_result     r;
        int unsigned pay, st, asize, bp, ext, a, h, sz, i;
        pay = 0;
        st  = STATUS_OK;
        a   = rq.addr;
        case (rq.kind)
            KIND_INIT: begin
                brk = 16;
                tag_wr(0, 0);
                tag_wr(4, 9);
                tag_wr(8, 9);
                tag_wr(12, 1);
                rov = PRO;
                heap_up = 1'b1;
                live_blocks.delete();
                if (grow_heap(chunk_rounded()) == 0) st = STATUS_NOMEM;
            end
            KIND_ALLOC: begin
                if (!heap_up) st = STATUS_NOINIT;
                else if (rq.nbytes == 0) st = STATUS_ZERO;
                else begin
                    asize = (rq.nbytes <= 8) ? 16 : 8 * ((int'(rq.nbytes) + 15) / 8);
                    bp = next_fit_scan(asize);
                    if (bp == 0) begin
                        ext = (asize > chunk_rounded()) ? asize : chunk_rounded();
                        bp = grow_heap(ext);
                    end
                    if (bp == 0) st = STATUS_NOMEM;
                    else begin
                        place_block(bp, asize);
                        pay = bp;
                        live_blocks.push_back(bp);
                        ever_blocks.push_back(bp);
                    end
                end
            end
            KIND_FREE: begin
                if (!heap_up) st = STATUS_NOINIT;
                else if (a != 0 && (a & 7) == 0 && a >= 16 && a < brk) begin
                    h  = tag_rd(a - 4);
                    sz = h & ~32'd7;
                    if ((h & 1) != 0 && sz >= 16 && sz <= brk - a &&
                        tag_rd(a + sz - 8) == h) begin
                        tag_wr(a - 4, sz);
                        tag_wr(a + sz - 8, sz);
                        void'(coalesce(a));
                        for (i = 0; i < live_blocks.size(); i++)
                            if (live_blocks[i] == a) begin
                                live_blocks.delete(i);
                                break;
                            end
                    end
                end
            end
            default: ;
        endcase
        r.payload_address = pay[15:0];
        r.status = st[1:0];
        return r;
    endfunction

    task automatic queue_request(t_kind k, int unsigned nb, int unsigned ad);
        t_request rq;
        rq.kind   = k;
        rq.nbytes = nb[15:0];
        rq.addr   = ad[15:0];
        predicted_results.push_back(heap_outcome(rq));
        pending_requests.push_back(rq);
    endtask

    // a free target: mostly a live or earlier block, else zero, small, odd or past brk
    function automatic int unsigned pick_free_addr();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 80 && live_blocks.size() > 0)
            return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        if (sel < 88 && ever_blocks.size() > 0)
            return ever_blocks[$urandom_range(0, ever_blocks.size() - 1)];
        if (sel < 92) return 0;
        if (sel < 95) return $urandom_range(0, 15);
        if (sel < 98) return ($urandom_range(0, 65535) | 1);
        return $urandom_range(brk < 65535 ? brk : 65535, 65535);
    endfunction

    task automatic queue_random(int n);
        int unsigned sel, nb;
        repeat (n) begin
            sel = $urandom_range(0, 999);
            if (sel < 8) queue_request(KIND_INIT, $urandom, $urandom);
            else if (sel < 25) queue_request(KIND_NOP, $urandom, $urandom);
            else if (sel < 40) queue_request(KIND_ALLOC, 0, $urandom);
            else if (sel < 560) begin
                nb = $urandom_range(0, 99);
                if (nb < 70) nb = $urandom_range(1, 120);
                else if (nb < 95) nb = $urandom_range(1, 3000);
                else nb = $urandom_range(1, 65535);
                queue_request(KIND_ALLOC, nb, $urandom);
            end else queue_request(KIND_FREE, $urandom, pick_free_addr());
        end
    endtask

    task automatic settle();
        while (pending_requests.size() > 0 || predicted_results.size() > 0)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_chunk(logic [16:0] v);
        @(posedge i_clk);
        i_cfg_valid       <= 1'b1;
        i_cfg_chunk_bytes <= v;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        chunk_reg = v;
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // ---------------- request driver ----------------
    int burst_left;
    int gap_left;
    int quiet_cycles;

    always @(posedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            burst_left  <= 4;
            gap_left    <= 0;
        end else if (!i_req_valid || !o_req_stall) begin
            if (gap_left > 0) begin
                gap_left    <= gap_left - 1;
                i_req_valid <= 1'b0;
            end else if (pending_requests.size() > 0 && !sender_hold) begin
                rq = pending_requests.pop_front();
                i_req_valid     <= 1'b1;
                i_kind          <= rq.kind;
                i_request_bytes <= rq.nbytes;
                i_block_address <= rq.addr;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // ---------------- response monitor and watchdog ----------------
    int unsigned cyc;
    int holdoff_left;
    int holdoff_seen;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_rsp_stall  <= 1'b0;
            cyc          <= 0;
            holdoff_left <= 0;
            holdoff_seen <= 0;
            quiet_cycles <= 0;
        end else begin
            cyc <= cyc + 1;
            if ((o_rsp_valid && !i_rsp_stall) || (i_req_valid && !o_req_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("boundary_tag_heap_allocator verification failed");
                $finish;
            end
            if (o_rsp_valid && !i_rsp_stall) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected response", o_status, -1);
                end else begin
                    want = predicted_results.pop_front();
                    if (o_payload_address !== want.payload_address)
                        report_mismatch("payload_address", o_payload_address,
                                        want.payload_address);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                end
            end
            if (holdoff_seen != holdoff_asks) begin
                holdoff_seen <= holdoff_asks;
                holdoff_left <= 600;
                i_rsp_stall  <= 1'b1;
            end else if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                i_rsp_stall  <= 1'b1;
            end else if (cyc[9:8] == 2'd0) begin
                i_rsp_stall <= 1'b0;
            end else begin
                i_rsp_stall <= ($urandom_range(0, 2) == 0);
            end
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        i_rst_n           = 1'b0;
        i_req_valid       = 1'b0;
        i_kind            = KIND_NOP;
        i_request_bytes   = '0;
        i_block_address   = '0;
        i_rsp_stall       = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_chunk_bytes = CHUNK_RESET;
        fail_count        = 0;
        holdoff_asks      = 0;
        sender_hold       = 1'b0;
        heap_tags         = '{default: 0};
        brk               = 0;
        rov               = 0;
        heap_up           = 1'b0;
        chunk_reg         = CHUNK_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // before any init, then a basic directed set at the reset chunk
        queue_request(KIND_ALLOC, 24, 0);
        queue_request(KIND_FREE, 0, 16);
        queue_request(KIND_NOP, 16'hFFFF, 16'hFFFF);
        queue_request(KIND_INIT, 0, 0);
        queue_request(KIND_ALLOC, 0, 0);
        queue_request(KIND_ALLOC, 1, 0);
        queue_request(KIND_ALLOC, 8, 0);
        queue_request(KIND_ALLOC, 9, 0);
        queue_request(KIND_ALLOC, 3000, 0);
        queue_request(KIND_ALLOC, 65535, 0);
        queue_request(KIND_FREE, 0, 0);
        queue_request(KIND_FREE, 0, 20);
        queue_request(KIND_FREE, 0, 8);
        queue_request(KIND_FREE, 0, 16'hFFF8);
        queue_request(KIND_FREE, 0, live_blocks[1]);
        queue_request(KIND_FREE, 0, live_blocks[0]);
        queue_request(KIND_FREE, 0, ever_blocks[0]);
        queue_request(KIND_FREE, 0, live_blocks[0]);
        queue_request(KIND_ALLOC, 40, 0);
        queue_request(KIND_INIT, 0, 0);
        settle();

        // smallest chunk, with a long receiver hold-off under load
        write_chunk(17'd16);
        queue_request(KIND_INIT, 0, 0);
        queue_random(200);
        @(negedge i_clk);
        holdoff_asks++;
        settle();

        // chunk below the floor; sender pauses until every sent request answers
        write_chunk(17'd1);
        queue_request(KIND_INIT, 0, 0);
        queue_random(60);
        repeat (150) @(negedge i_clk);
        sender_hold = 1'b1;
        while (predicted_results.size() > pending_requests.size())
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        sender_hold = 1'b0;
        settle();
        write_chunk(17'd0);
        queue_request(KIND_INIT, 0, 0);
        queue_random(60);
        settle();

        // large chunks: init runs out of heap, or the heap fills so that growth fails
        write_chunk(17'h1FFFF);
        queue_request(KIND_INIT, 0, 0);
        queue_request(KIND_ALLOC, 5, 0);
        queue_request(KIND_FREE, 0, 16);
        queue_random(12);
        settle();
        write_chunk(17'd65536);
        queue_request(KIND_INIT, 0, 0);
        queue_request(KIND_ALLOC, 100, 0);
        settle();
        write_chunk(17'd65520);
        queue_request(KIND_INIT, 0, 0);
        queue_request(KIND_ALLOC, 65535, 0);
        queue_random(40);
        settle();

        repeat (5) begin
            write_chunk(17'($urandom_range(16, 8192)));
            queue_request(KIND_INIT, 0, 0);
            queue_random(100);
            settle();
        end
        write_chunk(CHUNK_RESET);
        queue_request(KIND_INIT, 0, 0);
        queue_random(130);
        settle();

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && predicted_results.size() == 0)
            $display("boundary_tag_heap_allocator verification clean");
        else
            $display("boundary_tag_heap_allocator verification failed");
        $finish;
    end

endmodule
